/* rtl/ptle_pkg.sv */
package ptle_pkg;

  // Width of a vertex index on the ports and in storage.
  localparam int unsigned IDX_W = 16;
  // Number of significant index bits (8..32); higher bits of an index are dropped.
  localparam int unsigned INDEX_BITS = 16;
  localparam logic [IDX_W-1:0] IDX_MASK =
    IDX_W'((64'hFFFF_FFFF >> (32 - INDEX_BITS)) & 64'hFFFF);

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned MAX_LINES = 4;
  localparam int unsigned LCNT_W = 3;  // holds 0..MAX_LINES
  localparam int unsigned LSEL_W = 2;  // selects one of MAX_LINES

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIMITIVE_MODE = 1'b0,
    REG_QUADS_SINGLE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_TRIANGLES  = 3'd0,
    MODE_TRI_STRIP  = 3'd1,
    MODE_TRI_FAN    = 3'd2,
    MODE_QUADS      = 3'd3,
    MODE_QUAD_STRIP = 3'd4,
    MODE_POLYGON    = 3'd5
  } prim_mode_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             batch_end;
  } vertex_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] line_start;
    logic [IDX_W-1:0] line_end;
    logic             last_line;
  } line_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] from_idx;
    logic [IDX_W-1:0] to_idx;
  } line_pair_t;

  // All lines caused by one vertex word.
  typedef struct packed {
    line_pair_t [MAX_LINES-1:0] pairs;
    logic [LCNT_W-1:0]          count;
  } line_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* rtl/ptle_front.sv */
module ptle_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vertex_valid,
  output logic                           vertex_stall,
  input  ptle_pkg::vertex_word_t         vertex,
  input  logic                           cfg_we,
  input  logic [ptle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ptle_pkg::queue_status_t        q_status,
  output logic                           push,
  output ptle_pkg::line_job_t            job
);
  import ptle_pkg::*;

  logic [2:0]       primitive_mode;
  logic             quads_single;
  logic [CNT_W-1:0] position_count;
  logic [2:0]       pos_mod6;      // position_count % 6, frozen at saturation
  logic [IDX_W-1:0] recent_indices [3];
  logic [IDX_W-1:0] group_indices [3];
  logic [IDX_W-1:0] batch_first_index;

  logic             accept;
  logic [IDX_W-1:0] v, a, b, c, f;
  logic [CNT_W-1:0] p;
  logic             p_odd;
  logic             is_end;

  assign v      = vertex.vertex_index & IDX_MASK;
  assign is_end = vertex.batch_end;
  assign p      = position_count;
  assign p_odd  = position_count[0];
  assign a      = recent_indices[0];
  assign b      = recent_indices[1];
  assign c      = recent_indices[2];
  assign f      = batch_first_index;

  assign vertex_stall = q_status.full;
  assign accept       = vertex_valid && !q_status.full;
  assign push         = accept && (job.count != '0);

  function automatic line_pair_t mk(input logic [IDX_W-1:0] s, input logic [IDX_W-1:0] e);
    line_pair_t r;
    r.from_idx = s;
    r.to_idx   = e;
    return r;
  endfunction

  // Line generation; pairs[0] goes out first.
  always_comb begin
    job.pairs = '0;
    job.count = '0;
    case (primitive_mode)
      MODE_TRIANGLES: begin
        if (pos_mod6 == 3'd2 || pos_mod6 == 3'd5) begin
          job.pairs[0] = mk(b, a);
          job.pairs[1] = mk(a, v);
          job.pairs[2] = mk(v, b);
          job.count    = LCNT_W'(3);
        end
      end
      MODE_TRI_STRIP: begin
        if (p == CNT_W'(2)) begin
          job.pairs[0] = mk(b, a);
          job.pairs[1] = mk(b, v);
          job.pairs[2] = mk(a, v);
          job.count    = LCNT_W'(3);
        end else if (p > CNT_W'(2)) begin
          job.pairs[0] = mk(b, v);
          job.pairs[1] = mk(a, v);
          job.count    = LCNT_W'(2);
        end
      end
      MODE_TRI_FAN: begin
        if (p == CNT_W'(2)) begin
          job.pairs[0] = mk(f, a);
          job.pairs[1] = mk(f, v);
          job.pairs[2] = mk(a, v);
          job.count    = LCNT_W'(3);
        end else if (p > CNT_W'(2)) begin
          job.pairs[0] = mk(f, v);
          job.pairs[1] = mk(a, v);
          job.count    = LCNT_W'(2);
        end
      end
      MODE_QUADS: begin
        if (quads_single) begin
          if (p == CNT_W'(3)) begin
            job.pairs[0] = mk(c, b);
            job.pairs[1] = mk(b, a);
            job.pairs[2] = mk(a, v);
            job.pairs[3] = mk(v, c);
            job.count    = LCNT_W'(4);
          end
        end else if (pos_mod6 == 3'd5) begin
          job.pairs[0] = mk(group_indices[0], group_indices[1]);
          job.pairs[1] = mk(group_indices[1], group_indices[2]);
          job.pairs[2] = mk(group_indices[2], v);
          job.pairs[3] = mk(v, group_indices[0]);
          job.count    = LCNT_W'(4);
        end
      end
      MODE_QUAD_STRIP: begin
        if (p == CNT_W'(3)) begin
          job.pairs[0] = mk(c, b);
          job.pairs[1] = mk(b, a);
          job.pairs[2] = mk(c, v);
          job.pairs[3] = mk(a, v);
          job.count    = LCNT_W'(4);
        end else if (p > CNT_W'(3) && p_odd) begin
          job.pairs[0] = mk(b, a);
          job.pairs[1] = mk(c, v);
          job.pairs[2] = mk(a, v);
          job.count    = LCNT_W'(3);
        end
      end
      MODE_POLYGON: begin
        if (p != '0) begin
          job.pairs[0] = mk(a, v);
          if (is_end) begin
            job.pairs[1] = mk(v, f);
            job.count    = LCNT_W'(2);
          end else begin
            job.count    = LCNT_W'(1);
          end
        end else if (is_end) begin
          // single-index polygon: degenerate closing line
          job.pairs[0] = mk(v, v);
          job.count    = LCNT_W'(1);
        end
      end
      default: begin
        job.count = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primitive_mode <= '0;
      quads_single   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRIMITIVE_MODE: primitive_mode <= cfg_data;
        REG_QUADS_SINGLE:   quads_single   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      pos_mod6       <= '0;
    end else if (accept) begin
      if (is_end) begin
        position_count <= '0;
        pos_mod6       <= '0;
      end else if (position_count != COUNT_MAX) begin
        position_count <= position_count + CNT_W'(1);
        pos_mod6       <= (pos_mod6 == 3'd5) ? 3'd0 : pos_mod6 + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      recent_indices[2] <= b;
      recent_indices[1] <= a;
      recent_indices[0] <= v;
      if (pos_mod6 < 3'd3) begin
        group_indices[pos_mod6[1:0]] <= v;
      end
      if (position_count == '0) begin
        batch_first_index <= v;
      end
    end
  end

endmodule

/* rtl/ptle_queue.sv */
module ptle_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ptle_pkg::line_job_t     push_job,
  input  logic                    pop,
  output ptle_pkg::line_job_t     head_job,
  output ptle_pkg::queue_status_t status
);
  import ptle_pkg::*;

  line_job_t      entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign status.full  = (fill == (QAW+1)'(QDEPTH));
  assign status.empty = (fill == '0);
  assign head_job     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* rtl/ptle_back.sv */
module ptle_back (
  input  logic                    clk,
  input  logic                    rst,
  input  ptle_pkg::line_job_t     head_job,
  input  ptle_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    line_valid,
  input  logic                    line_stall,
  output ptle_pkg::line_word_t    line
);
  import ptle_pkg::*;

  logic [LSEL_W-1:0] sel;
  logic [LSEL_W-1:0] sel_next;
  logic              load;
  logic              is_last;
  logic              line_valid_next;
  line_word_t        line_next;

  assign load    = (!line_valid || !line_stall) && !q_status.empty;
  assign is_last = ({1'b0, sel} == head_job.count - LCNT_W'(1));
  assign pop     = load && is_last;

  always_comb begin
    line_next.line_start = head_job.pairs[sel].from_idx;
    line_next.line_end   = head_job.pairs[sel].to_idx;
    line_next.last_line  = is_last;
    if (load) begin
      sel_next        = is_last ? '0 : sel + LSEL_W'(1);
      line_valid_next = 1'b1;
    end else begin
      sel_next        = sel;
      line_valid_next = line_valid && line_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel        <= '0;
      line_valid <= 1'b0;
    end else begin
      sel        <= sel_next;
      line_valid <= line_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line <= line_next;
    end
  end

endmodule

/* rtl/primitive_to_line_index_expander_unit.sv */
// Wireframe line expander for filled-primitive index batches.
//
// Vertex channel (vertex_valid / vertex_stall / vertex): one vertex index
// per word, batch_end set on the last index of a batch. Line channel
// (line_valid / line_stall / line): one line segment per word, last_line
// set on the final line caused by a vertex word.
// Config port: cfg_we with cfg_index 0 = primitive_mode, 1 = quads_single;
// write only while the block is idle.
//
// The front stage takes a vertex word in any cycle the line-job queue
// (4 entries) has room, and turns it into 0..4 lines in the same cycle.
// The back stage sends one line per cycle from an output register while
// line_stall is low and the queue holds a job; the first line of a vertex
// word is written into the queue, then loaded into the output register.
// Sustained rate is set by the one-line output and the lines per index.
// A stalled line word is held; the queue keeps taking vertices until full,
// then vertex_stall rises.
// Reset (rst, synchronous) empties queue and output, clears the batch
// position and sets both config registers to zero.
module primitive_to_line_index_expander_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            vertex_valid,
  output logic                            vertex_stall,
  input  ptle_pkg::vertex_word_t          vertex,
  output logic                            line_valid,
  input  logic                            line_stall,
  output ptle_pkg::line_word_t            line,
  input  logic                            cfg_we,
  input  logic [ptle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptle_pkg::*;

  // front -> queue
  logic          push;
  line_job_t     push_job;
  // queue -> back
  line_job_t     head_job;
  queue_status_t q_status;
  logic          pop;

  ptle_front u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_status     (q_status),
    .push         (push),
    .job          (push_job)
  );

  ptle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  ptle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_status   (q_status),
    .pop        (pop),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .line       (line)
  );

endmodule

/* rtl/ptle_checker.sv */
module ptle_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   vertex_valid,
  input logic                   vertex_stall,
  input logic                   line_valid,
  input logic                   line_stall,
  input ptle_pkg::line_word_t   line
);
  import ptle_pkg::*;

  // Reset empties the output register.
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !line_valid)
    else $error("line_valid set after reset");

  // Queue is empty after reset, so vertices are taken at once.
  a_ready_after_reset: assert property (@(posedge clk) $past(rst) |-> !vertex_stall)
    else $error("vertex_stall high right after reset");

  // Queue only fills through an accepted vertex word.
  a_stall_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(vertex_stall) |-> $past(vertex_valid && !vertex_stall))
    else $error("vertex_stall rose without a vertex accepted");

  // A stalled line word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    line_valid && line_stall |=> line_valid && $stable(line))
    else $error("stalled line word changed");

endmodule

bind primitive_to_line_index_expander_unit ptle_checker u_ptle_checker (
  .clk          (clk),
  .rst          (rst),
  .vertex_valid (vertex_valid),
  .vertex_stall (vertex_stall),
  .line_valid   (line_valid),
  .line_stall   (line_stall),
  .line         (line)
);
